// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/lsbse_pkg.sv =====
package lsbse_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_PAIR = 2'd0,
    OP_LOAD_MSG  = 2'd1,
    OP_IMAGE     = 2'd2,
    OP_START     = 2'd3
  } opcode_t;

  localparam logic [2:0] REG_DIRECTION    = 3'd0;
  localparam logic [2:0] REG_PALETTE_MODE = 3'd1;
  localparam logic [2:0] REG_PIXEL_BYTES  = 3'd2;
  localparam logic [2:0] REG_ROW_PIXELS   = 3'd3;
  localparam logic [2:0] REG_MAX_MSG_LEN  = 3'd4;

  localparam logic [7:0] LSB_CLEAR_MASK = 8'hFE;
  localparam logic [2:0] LAST_BIT_POS   = 3'd7;
  localparam logic [2:0] MAX_PIXEL_BYTES = 3'd4;

endpackage

// ===== sv/lsb_stego_embed_extract_core.sv =====
// Channel   Handshake                  Payload
// in        in_valid / in_ready        opcode, entry_index, entry_paired, data_byte
// out       out_valid / out_ready      out_byte, out_kind, last
// cfg       psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item per cycle sustained while the result register is not stalled; each item passes
// through the input stage (pair table and message store read there) and then the result register.
// out_valid rises when the result register is loaded, and only for items that yield a result.
// rst is synchronous and clears all control state and the pair valid bits.
// A stalled result register holds the input stage, which then drops in_ready.
module lsb_stego_embed_extract_core #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int MESSAGE_DEPTH   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  entry_index,
  input  logic        entry_paired,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_kind,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lsbse_pkg::*;

  localparam int IW  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int AW  = $clog2(MESSAGE_DEPTH);
  localparam int CW  = $clog2(MESSAGE_DEPTH + 1);
  localparam int PW0 = $clog2(MESSAGE_DEPTH + 2);
  localparam int PW  = (PW0 > 9) ? PW0 : 9;

  logic        direction;
  logic        palette_mode;
  logic [2:0]  pixel_bytes;
  logic [15:0] row_pixels;
  logic [8:0]  max_message_length;

  logic [8:0]  pair_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] pair_written;
  logic [7:0]  msg_mem [MESSAGE_DEPTH];

  logic [CW-1:0] message_count;
  logic [PW-1:0] message_pos, message_pos_next;
  logic [2:0]    bit_pos, bit_pos_next;
  logic [17:0]   row_offset, row_offset_next;
  logic [1:0]    pixel_phase, pixel_phase_next;
  logic [7:0]    gathered_byte, gathered_byte_next;
  logic          finished, finished_next;

  logic          s_valid;
  opcode_t       s_op;
  logic [7:0]    s_byte;
  logic          s_in_table;
  logic [8:0]    s_entry;
  logic [7:0]    msg_rdata;

  logic          accept, advance, cfg_write;
  logic          res_valid, res_kind, res_last;
  logic [7:0]    res_byte;

  logic [2:0]    pb_eff;
  logic [15:0]   rp_eff;
  logic [17:0]   row_len, offset_inc;
  logic [2:0]    phase_p1, phase_m1, phase_m2;
  logic [1:0]    phase_adv;
  logic          carrier, paired, ext_bit, emb_bit, bit_ok;
  logic [7:0]    partner, pal_hi, pal_lo, gathered_new;
  logic [8:0]    limit;
  logic [PW-1:0] pos_inc;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign advance   = s_valid & (~out_valid | out_ready);
  assign in_ready  = ~s_valid | advance;
  assign accept    = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction          <= 1'b0;
      palette_mode       <= 1'b0;
      pixel_bytes        <= 3'd1;
      row_pixels         <= 16'd1;
      max_message_length <= 9'd256;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_DIRECTION:    direction          <= pwdata[0];
        REG_PALETTE_MODE: palette_mode       <= pwdata[0];
        REG_PIXEL_BYTES:  pixel_bytes        <= pwdata[2:0];
        REG_ROW_PIXELS:   row_pixels         <= pwdata[15:0];
        REG_MAX_MSG_LEN:  max_message_length <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_DIRECTION:    prdata = {31'd0, direction};
      REG_PALETTE_MODE: prdata = {31'd0, palette_mode};
      REG_PIXEL_BYTES:  prdata = {29'd0, pixel_bytes};
      REG_ROW_PIXELS:   prdata = {16'd0, row_pixels};
      REG_MAX_MSG_LEN:  prdata = {23'd0, max_message_length};
      default:          prdata = 32'd0;
    endcase
  end

  // Table and store writes take effect at the input transfer.
  always_ff @(posedge clk) begin
    if (accept && opcode_t'(opcode) == OP_LOAD_PAIR &&
        {1'b0, entry_index} < 9'(PALETTE_ENTRIES)) begin
      pair_mem[entry_index[IW-1:0]] <= {entry_paired, data_byte};
    end
    if (accept) begin
      s_entry <= pair_mem[data_byte[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_written <= '0;
    end else if (accept && opcode_t'(opcode) == OP_LOAD_PAIR &&
                 {1'b0, entry_index} < 9'(PALETTE_ENTRIES)) begin
      pair_written[entry_index[IW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && opcode_t'(opcode) == OP_LOAD_MSG &&
        message_count < CW'(MESSAGE_DEPTH)) begin
      msg_mem[message_count[AW-1:0]] <= data_byte;
    end
    msg_rdata <= msg_mem[message_pos_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_count <= '0;
    end else if (accept && opcode_t'(opcode) == OP_LOAD_MSG &&
                 message_count < CW'(MESSAGE_DEPTH)) begin
      message_count <= message_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_op       <= opcode_t'(opcode);
      s_byte     <= data_byte;
      s_in_table <= ({1'b0, data_byte} < 9'(PALETTE_ENTRIES)) &&
                    pair_written[data_byte[IW-1:0]];
    end
  end

  always_comb begin
    if (pixel_bytes == 3'd0) begin
      pb_eff = 3'd1;
    end else if (pixel_bytes > MAX_PIXEL_BYTES) begin
      pb_eff = MAX_PIXEL_BYTES;
    end else begin
      pb_eff = pixel_bytes;
    end
  end

  assign rp_eff     = (row_pixels == 16'd0) ? 16'd1 : row_pixels;
  assign row_len    = 18'd1 + 18'(pb_eff) * 18'(rp_eff);
  assign offset_inc = row_offset + 18'd1;
  assign phase_p1   = {1'b0, pixel_phase} + 3'd1;
  assign phase_m1   = (phase_p1 >= pb_eff) ? phase_p1 - pb_eff : phase_p1;
  assign phase_m2   = (phase_m1 >= pb_eff) ? phase_m1 - pb_eff : phase_m1;
  assign phase_adv  = (pb_eff == 3'd1) ? 2'd0 : phase_m2[1:0];

  assign carrier  = (row_offset != 18'd0) && (pixel_phase == 2'd0);
  assign paired   = s_in_table & s_entry[8];
  assign partner  = s_entry[7:0];
  assign pal_hi   = (s_byte > partner) ? s_byte : partner;
  assign pal_lo   = (s_byte < partner) ? s_byte : partner;
  assign emb_bit  = msg_rdata[bit_pos];
  assign ext_bit  = palette_mode ? (s_byte > partner) : s_byte[0];
  assign bit_ok   = ~palette_mode | paired;
  assign gathered_new = gathered_byte | (8'(ext_bit) << bit_pos);
  assign limit    = (max_message_length == 9'd0) ? 9'd1 : max_message_length;
  assign pos_inc  = message_pos + PW'(1);

  always_comb begin
    message_pos_next   = message_pos;
    bit_pos_next       = bit_pos;
    row_offset_next    = row_offset;
    pixel_phase_next   = pixel_phase;
    gathered_byte_next = gathered_byte;
    finished_next      = finished;
    res_valid          = 1'b0;
    res_byte           = s_byte;
    res_kind           = 1'b0;
    res_last           = 1'b0;
    if (advance) begin
      unique case (s_op)
        OP_LOAD_PAIR, OP_LOAD_MSG: ;
        OP_START: begin
          message_pos_next   = '0;
          bit_pos_next       = 3'd0;
          row_offset_next    = 18'd0;
          pixel_phase_next   = 2'd0;
          gathered_byte_next = 8'd0;
          finished_next      = 1'b0;
        end
        OP_IMAGE: begin
          pixel_phase_next = (row_offset == 18'd0) ? 2'd0 : phase_adv;
          row_offset_next  = offset_inc;
          if (offset_inc >= row_len) begin
            row_offset_next  = 18'd0;
            pixel_phase_next = 2'd0;
          end
          if (!direction) begin
            res_valid = 1'b1;
            if (carrier && message_pos < PW'(message_count) && bit_ok) begin
              res_byte = palette_mode ? (emb_bit ? pal_hi : pal_lo)
                                      : ((s_byte & LSB_CLEAR_MASK) | 8'(emb_bit));
              if (bit_pos == LAST_BIT_POS) begin
                bit_pos_next     = 3'd0;
                message_pos_next = pos_inc;
              end else begin
                bit_pos_next = bit_pos + 3'd1;
              end
            end
          end else if (!finished && carrier && bit_ok) begin
            if (bit_pos != LAST_BIT_POS) begin
              gathered_byte_next = gathered_new;
              bit_pos_next       = bit_pos + 3'd1;
            end else begin
              res_valid          = 1'b1;
              res_byte           = gathered_new;
              res_kind           = 1'b1;
              res_last           = (gathered_new == 8'd0) || (pos_inc >= PW'(limit));
              finished_next      = res_last;
              bit_pos_next       = 3'd0;
              message_pos_next   = pos_inc;
              gathered_byte_next = 8'd0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_pos   <= '0;
      bit_pos       <= 3'd0;
      row_offset    <= 18'd0;
      pixel_phase   <= 2'd0;
      gathered_byte <= 8'd0;
      finished      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      message_pos   <= message_pos_next;
      bit_pos       <= bit_pos_next;
      row_offset    <= row_offset_next;
      pixel_phase   <= pixel_phase_next;
      gathered_byte <= gathered_byte_next;
      finished      <= finished_next;
      if (advance) begin
        out_valid <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_byte <= res_byte;
      out_kind <= res_kind;
      last     <= res_last;
    end
  end

endmodule

// ===== sv/lsbse_checker.sv =====
`include "assert_macros.svh"

module lsbse_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_kind,
  input logic        last,
  input logic        psel,
  input logic        pready
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_kind) && $stable(last), "stalled result changed")
  `ASSERT_NOW(a_last_is_message, clk, rst, out_valid && last, out_kind, "last on a scanline byte")
  `ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ready, "input stalled with empty result register")
  `ASSERT_NOW(a_pready_high, clk, rst, psel, pready, "configuration port not ready")

endmodule

bind lsb_stego_embed_extract_core lsbse_checker u_lsbse_checker (.*);

// ===== tb/lsb_stego_embed_extract_core_tb.sv =====
module lsb_stego_embed_extract_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsbse_pkg::*;

  localparam int ITEM_TARGET = 1800;

  typedef struct packed {
    logic [7:0] obyte;
    logic       okind;
    logic       olast;
  } stego_out_t;

  typedef struct {
    logic        is_cfg;
    logic [2:0]  rid;
    logic [31:0] val;
    opcode_t     op;
    logic [7:0]  idx;
    logic        paired;
    logic [7:0]  data;
    logic        typed;
    stego_out_t  want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [7:0]  entry_index;
  logic        entry_paired;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_kind;
  logic        last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lsb_stego_embed_extract_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .entry_index  (entry_index),
    .entry_paired (entry_paired),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_kind     (out_kind),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // predictor copy of registers and state
  logic        m_dir;
  logic        m_pal;
  logic [2:0]  m_pb;
  logic [15:0] m_rp;
  logic [8:0]  m_maxlen;
  logic [8:0]  pair_mem [256];
  logic [7:0]  msg_mem [256];
  logic [8:0]  msg_cnt;
  logic [8:0]  msg_pos;
  logic [2:0]  bit_idx;
  logic [17:0] row_off;
  logic [1:0]  phase;
  logic [7:0]  gather;
  logic        done;

  stego_out_t  pending_bytes [$];
  stim_row_t   script [$];
  logic [7:0]  pair_list [$];
  stego_out_t  rx_want;
  int          errors;
  int          items_sent;
  logic        tx_burst;
  logic        rx_free;
  int          rx_hold;

  function automatic logic pair_of(input logic [7:0] b, output logic [7:0] partner);
    partner = pair_mem[b][7:0];
    return pair_mem[b][8];
  endfunction

  function automatic logic stego_step(input opcode_t op, input logic [7:0] idx,
                                      input logic pd, input logic [7:0] b,
                                      output stego_out_t res);
    logic       carrier;
    logic       used;
    logic       bitv;
    logic [7:0] partner;
    logic [7:0] hi;
    logic [7:0] lo;
    int         pb;
    int         rlen;
    int         lim;
    res = '0;
    case (op)
      OP_LOAD_PAIR: begin
        pair_mem[idx] = {pd, b};
        return 1'b0;
      end
      OP_LOAD_MSG: begin
        if (msg_cnt < 256) begin
          msg_mem[msg_cnt[7:0]] = b;
          msg_cnt++;
        end
        return 1'b0;
      end
      OP_START: begin
        row_off = '0;
        phase   = '0;
        msg_pos = '0;
        bit_idx = '0;
        gather  = '0;
        done    = 1'b0;
        return 1'b0;
      end
      default: ;
    endcase

    pb = (m_pb == 0) ? 1 : (m_pb > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : m_pb;
    rlen = 1 + pb * ((m_rp == 0) ? 1 : m_rp);
    carrier = (row_off != 0) && (phase == 0);
    if (row_off == 0) phase = '0;
    else phase = 2'((phase + 1) % pb);
    row_off = row_off + 18'd1;
    if (row_off >= rlen) begin
      row_off = '0;
      phase   = '0;
    end

    if (!m_dir) begin
      res.obyte = b;
      if (carrier && msg_pos < msg_cnt) begin
        bitv = msg_mem[msg_pos[7:0]][bit_idx];
        used = 1'b1;
        if (m_pal) begin
          if (pair_of(b, partner)) begin
            hi = (b > partner) ? b : partner;
            lo = (b < partner) ? b : partner;
            res.obyte = bitv ? hi : lo;
          end else begin
            used = 1'b0;
          end
        end else begin
          res.obyte = (b & LSB_CLEAR_MASK) | 8'(bitv);
        end
        if (used) begin
          if (bit_idx == LAST_BIT_POS) begin
            bit_idx = '0;
            msg_pos++;
          end else begin
            bit_idx++;
          end
        end
      end
      return 1'b1;
    end

    if (done || !carrier) return 1'b0;
    if (m_pal) begin
      if (!pair_of(b, partner)) return 1'b0;
      bitv = b > partner;
    end else begin
      bitv = b[0];
    end
    gather = gather | (8'(bitv) << bit_idx);
    if (bit_idx != LAST_BIT_POS) begin
      bit_idx++;
      return 1'b0;
    end
    bit_idx   = '0;
    res.obyte = gather;
    res.okind = 1'b1;
    msg_pos++;
    lim = (m_maxlen == 0) ? 1 : m_maxlen;
    if (gather == 0 || msg_pos >= lim) begin
      done      = 1'b1;
      res.olast = 1'b1;
    end
    gather = '0;
    return 1'b1;
  endfunction

  function automatic void add_item(input opcode_t op, input logic [7:0] idx, input logic pd,
                                   input logic [7:0] b, input logic typed = 1'b0,
                                   input stego_out_t want = '0);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.rid    = '0;
    r.val    = '0;
    r.op     = op;
    r.idx    = idx;
    r.paired = pd;
    r.data   = b;
    r.typed  = typed;
    r.want   = want;
    script.push_back(r);
  endfunction

  function automatic void add_reg(input logic [2:0] rid, input logic [31:0] val);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.rid    = rid;
    r.val    = val;
    r.op     = OP_IMAGE;
    r.idx    = '0;
    r.paired = 1'b0;
    r.data   = '0;
    r.typed  = 1'b0;
    r.want   = '0;
    script.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input opcode_t op, input logic [7:0] idx, input logic pd,
                           input logic [7:0] b, input logic typed = 1'b0,
                           input stego_out_t want = '0);
    int         gap;
    logic       hasres;
    stego_out_t res;
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    entry_index  <= idx;
    entry_paired <= pd;
    data_byte    <= b;
    do @(posedge clk); while (!in_ready);
    hasres = stego_step(op, idx, pd, b, res);
    if (typed) pending_bytes.push_back(want);
    else if (hasres) pending_bytes.push_back(res);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] rid, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {rid, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (rid)
      REG_DIRECTION:    m_dir    = val[0];
      REG_PALETTE_MODE: m_pal    = val[0];
      REG_PIXEL_BYTES:  m_pb     = val[2:0];
      REG_ROW_PIXELS:   m_rp     = val[15:0];
      REG_MAX_MSG_LEN:  m_maxlen = val[8:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned len;
    out_ready = 1'b0;
    len = 0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else if (len > 0) begin
        len--;
      end else if (rx_free || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        len = rx_free ? 0 : $urandom_range(0, 20);
      end else begin
        out_ready <= 1'b0;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 3);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected result: byte %02h kind %0d last %0d",
                 $time, out_byte, out_kind, last);
        errors++;
      end else begin
        rx_want = pending_bytes.pop_front();
        if (out_byte !== rx_want.obyte || out_kind !== rx_want.okind ||
            last !== rx_want.olast) begin
          $display("%0t: mismatch: expected byte %02h kind %0d last %0d, got %02h %0d %0d",
                   $time, rx_want.obyte, rx_want.okind, rx_want.olast,
                   out_byte, out_kind, last);
          errors++;
        end
      end
    end
  end

  initial begin
    int          len;
    int          phase_no;
    logic        pressure_done;
    logic        msg_full;
    logic        car;
    logic        used;
    logic        dir;
    logic [7:0]  a;
    logic [7:0]  c;
    logic [7:0]  b;
    logic [7:0]  partner;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  tgt_byte;
    logic [2:0]  tgt_bit;
    logic [31:0] pbv;
    logic [31:0] rpv;
    logic [31:0] mlv;

    in_valid     = 1'b0;
    opcode       = OP_IMAGE;
    entry_index  = '0;
    entry_paired = 1'b0;
    data_byte    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    errors       = 0;
    items_sent   = 0;
    tx_burst     = 1'b0;
    rx_free      = 1'b0;
    rx_hold      = 0;
    m_dir        = 1'b0;
    m_pal        = 1'b0;
    m_pb         = 3'd1;
    m_rp         = 16'd1;
    m_maxlen     = 9'd256;
    for (int i = 0; i < 256; i++) begin
      pair_mem[i] = '0;
      msg_mem[i]  = '0;
    end
    msg_cnt  = '0;
    msg_pos  = '0;
    bit_idx  = '0;
    row_off  = '0;
    phase    = '0;
    gather   = '0;
    done     = 1'b0;

    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: filter byte, then a carrier with an empty message
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'h00, 1'b1, {8'h00, 1'b0, 1'b0});
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'hFF, 1'b1, {8'hFF, 1'b0, 1'b0});
    add_item(OP_LOAD_MSG, 8'h00, 1'b0, 8'hA5);
    add_item(OP_LOAD_PAIR, 8'h00, 1'b1, 8'hFF);
    add_item(OP_LOAD_PAIR, 8'hFF, 1'b1, 8'h00);
    add_item(OP_LOAD_PAIR, 8'h20, 1'b0, 8'h21);
    add_reg(REG_ROW_PIXELS, 32'd4);
    add_item(OP_START, 8'h00, 1'b0, 8'h00);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'hFF);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'hFF);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'h00);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'hFF);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'h00);
    add_reg(REG_PALETTE_MODE, 32'd1);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'h20);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'h20);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'h00);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'hFF);
    // extract one byte with a length limit of one
    add_reg(REG_DIRECTION, 32'd1);
    add_reg(REG_PALETTE_MODE, 32'd0);
    add_reg(REG_ROW_PIXELS, 32'd65535);
    add_reg(REG_MAX_MSG_LEN, 32'd1);
    add_item(OP_START, 8'h00, 1'b0, 8'h00);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'h00);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'hFE);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'h00);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'h01);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'hFF);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'h03);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'h81);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'h10);
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'hEE, 1'b1, {8'h3C, 1'b1, 1'b1});
    add_item(OP_IMAGE, 8'h00, 1'b0, 8'h01);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain();
        reg_write(script[i].rid, script[i].val);
      end else begin
        send_item(script[i].op, script[i].idx, script[i].paired, script[i].data,
                  script[i].typed, script[i].want);
      end
    end

    for (int k = 0; k < 40; k++) begin
      a = 8'($urandom);
      c = ($urandom_range(0, 7) == 0) ? a : 8'($urandom);
      send_item(OP_LOAD_PAIR, a, 1'b1, c);
      send_item(OP_LOAD_PAIR, c, 1'b1, a);
      pair_list.push_back(a);
    end
    repeat (6) send_item(OP_LOAD_PAIR, 8'($urandom), 1'b0, 8'($urandom));

    phase_no      = 0;
    pressure_done = 1'b0;
    msg_full      = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      dir = 1'($urandom_range(0, 1));
      rx_free  = (phase_no % 5 == 4);
      tx_burst = rx_free;
      if (!pressure_done && items_sent > 500) dir = 1'b0;
      pbv = ($urandom_range(0, 7) < 6) ? $urandom_range(1, 4) : $urandom_range(0, 7);
      case ($urandom_range(0, 7))
        0:       rpv = 0;
        1:       rpv = 65535;
        2:       rpv = $urandom_range(0, 65535);
        default: rpv = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 5))
        0:       mlv = 0;
        1:       mlv = 1;
        2:       mlv = 256;
        3:       mlv = $urandom_range(0, 511);
        default: mlv = $urandom_range(1, 6);
      endcase
      reg_write(REG_DIRECTION, {31'd0, dir});
      reg_write(REG_PALETTE_MODE, $urandom_range(0, 1));
      reg_write(REG_PIXEL_BYTES, pbv);
      reg_write(REG_ROW_PIXELS, rpv);
      reg_write(REG_MAX_MSG_LEN, mlv);

      if (!pressure_done && items_sent > 500) begin
        tx_burst      = 1'b1;
        rx_hold       = 300;
        pressure_done = 1'b1;
      end
      if (!m_dir && msg_cnt < 256 && $urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 4))
          send_item(OP_LOAD_MSG, 8'($urandom), 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom));
      if (items_sent > 1500 && !msg_full) begin
        while (msg_cnt < 256) send_item(OP_LOAD_MSG, 8'($urandom), 1'b0, 8'($urandom));
        repeat (3) send_item(OP_LOAD_MSG, 8'($urandom), 1'b1, 8'($urandom));
        msg_full = 1'b1;
      end
      if ($urandom_range(0, 4) != 0) send_item(OP_START, 8'($urandom), 1'b0, 8'($urandom));

      tgt_byte = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      tgt_bit  = '0;
      len = $urandom_range(20, 120);
      repeat (len) begin
        if ($urandom_range(0, 99) < 6) begin
          case ($urandom_range(0, 2))
            0: send_item(OP_LOAD_PAIR, 8'($urandom), 1'($urandom_range(0, 1)),
                         8'($urandom));
            1: send_item(OP_LOAD_MSG, 8'($urandom), 1'($urandom_range(0, 1)),
                         8'($urandom));
            default: begin
              send_item(OP_START, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom));
              tgt_bit = '0;
            end
          endcase
        end else begin
          b   = 8'($urandom);
          car = (row_off != 0) && (phase == 0);
          if (m_pal && pair_list.size() != 0 && $urandom_range(0, 4) != 0)
            b = pair_list[$urandom_range(0, pair_list.size() - 1)];
          if (m_dir && car && $urandom_range(0, 9) != 0) begin
            if (m_pal) begin
              if (pair_of(b, partner)) begin
                hi = (b > partner) ? b : partner;
                lo = (b > partner) ? partner : b;
                b  = tgt_byte[tgt_bit] ? hi : lo;
              end
              used = pair_of(b, partner);
            end else begin
              b[0] = tgt_byte[tgt_bit];
              used = 1'b1;
            end
            if (used) begin
              if (tgt_bit == LAST_BIT_POS) begin
                tgt_bit  = '0;
                tgt_byte = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
              end else begin
                tgt_bit++;
              end
            end
          end
          send_item(OP_IMAGE, 8'($urandom), 1'($urandom_range(0, 1)), b);
        end
      end
      phase_no++;
    end

    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
